/* hdl/pba_pkg.sv */
// Shared types and constants for the page bitmap allocator.
// Holds the bitmap geometry, status codes and the controller/datapath links.
// No dependencies.
`default_nettype none

package pba_pkg;

  localparam int MAP_WORDS  = 32;
  localparam int WORD_BITS  = 32;
  localparam int BIT_W      = 5;
  localparam int IDX_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int PAGE_SHIFT = 12;
  localparam int BASE_W     = 20;
  localparam int ADDR_W     = 32;
  localparam int MAP_PAGES  = MAP_WORDS * WORD_BITS;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_OUTSIDE = 2'd2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic load;
    logic scan_clr;
    logic rd_scan;
    logic rd_free;
    logic wr_alloc;
    logic wr_free;
    logic out_full;
    logic out_outside;
  } dp_cmd_t;

  typedef struct packed {
    logic word_full;
    logic last_word;
    logic outside;
    logic out_free;
  } dp_stat_t;

  function automatic logic [BIT_W-1:0] lowest_clear(input logic [WORD_BITS-1:0] w);
    logic [BIT_W-1:0] r;
    r = BIT_W'(WORD_BITS - 1);
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!w[b]) r = BIT_W'(b);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hdl/page_bitmap_allocator.sv */
// Top level of the page bitmap allocator: joins pba_ctrl and pba_dp.
// Depends on pba_pkg, pba_ctrl and pba_dp.
//
//   channel  | direction | word
//   s_axis   | in        | tdata page_addr[31:0], tuser op
//   m_axis   | out       | tdata result_addr[31:0], tuser status[1:0]
//   cfg      | in        | cfg_data heap_base_page[19:0]
//
// An allocate scans the bitmap words in order (1 to 32, one per cycle
// through the registered read port) and sets the lowest clear bit of the
// first word with one, else reports full; a free clears the bit
// of its page, or reports outside when its address lies outside the heap.
// Reset clears the bitmap at once through one valid bit per word.
// A stalled m_axis holds the finished word in the output register; the next
// word is taken meanwhile and waits only at its final step.
`default_nettype none

module page_bitmap_allocator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] page_addr
  input  wire logic [0:0]  s_axis_tuser,   // [0] op
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [31:0] result_addr
  output logic [1:0]       m_axis_tuser,   // [1:0] status
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [19:0] cfg_data
);

  pba_pkg::dp_cmd_t  cmd;
  pba_pkg::dp_stat_t stat;

  assign cfg_ready = !rst;

  pba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_op    (s_axis_tuser[0]),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pba_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_addr    (s_axis_tdata),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_base   (cfg_data),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_addr   (m_axis_tdata),
    .out_status (m_axis_tuser)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken again while a request is in progress");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == pba_pkg::ST_OK ||
                       m_axis_tuser == pba_pkg::ST_FULL ||
                       m_axis_tuser == pba_pkg::ST_OUTSIDE))
    else $error("result status outside defined codes");

  a_fail_zero_addr: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser != pba_pkg::ST_OK) |-> (m_axis_tdata == '0))
    else $error("failed request carries a non-zero address");
`endif

endmodule

`default_nettype wire

/* hdl/pba_dp.sv */
// Datapath of the page bitmap allocator: bitmap memory, scan pointer,
// free-address arithmetic, base register and output register.
// Depends on pba_pkg.
`default_nettype none

module pba_dp (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire pba_pkg::dp_cmd_t                  cmd,
  output pba_pkg::dp_stat_t                      stat,
  input  wire logic [pba_pkg::ADDR_W-1:0]        in_addr,
  input  wire logic                              cfg_we,
  input  wire logic [pba_pkg::BASE_W-1:0]        cfg_base,
  input  wire logic                              out_ready,
  output logic                                   out_valid,
  output logic [pba_pkg::ADDR_W-1:0]             out_addr,
  output logic [1:0]                             out_status
);

  logic [pba_pkg::WORD_BITS-1:0] mem [pba_pkg::MAP_WORDS];
  logic [pba_pkg::MAP_WORDS-1:0] word_vld;

  logic [pba_pkg::ADDR_W-1:0]    req_addr;
  logic [pba_pkg::BASE_W-1:0]    base;
  logic [pba_pkg::IDX_W-1:0]     scan_ptr;
  logic [pba_pkg::IDX_W-1:0]     rd_word;
  logic [pba_pkg::WORD_BITS-1:0] rd_data;
  logic                          rd_vld;

  logic [pba_pkg::WORD_BITS-1:0] cur_word;
  logic [pba_pkg::BIT_W-1:0]     alloc_bit;
  logic [pba_pkg::BASE_W-1:0]    alloc_pg;
  logic [pba_pkg::BASE_W-1:0]    rel_page;
  logic [pba_pkg::IDX_W-1:0]     free_word;
  logic [pba_pkg::BIT_W-1:0]     free_bit;
  logic [pba_pkg::IDX_W-1:0]     rd_addr;
  logic                          out_free;

  assign cur_word   = rd_vld ? rd_data : '0;
  assign alloc_bit  = pba_pkg::lowest_clear(cur_word);
  assign alloc_pg   = base + pba_pkg::BASE_W'({rd_word, alloc_bit});
  assign rel_page   = req_addr[pba_pkg::ADDR_W-1:pba_pkg::PAGE_SHIFT] - base;
  assign free_word  = rel_page[pba_pkg::IDX_W+pba_pkg::BIT_W-1:pba_pkg::BIT_W];
  assign free_bit   = rel_page[pba_pkg::BIT_W-1:0];
  assign rd_addr    = cmd.rd_free ? free_word : scan_ptr;
  assign out_free   = !out_valid || out_ready;

  assign stat.word_full = &cur_word;
  assign stat.last_word = (rd_word == pba_pkg::IDX_W'(pba_pkg::MAP_WORDS - 1));
  assign stat.outside   = (rel_page >= pba_pkg::BASE_W'(pba_pkg::MAP_PAGES));
  assign stat.out_free  = out_free;

  always_ff @(posedge clk) begin
    if (cmd.load) req_addr <= in_addr;
    if (cmd.rd_scan || cmd.rd_free) begin
      rd_word <= rd_addr;
      rd_data <= mem[rd_addr];
      rd_vld  <= word_vld[rd_addr];
    end
    if (cmd.wr_alloc) begin
      mem[rd_word] <= cur_word | (pba_pkg::WORD_BITS'(1) << alloc_bit);
    end else if (cmd.wr_free) begin
      mem[rd_word] <= cur_word & ~(pba_pkg::WORD_BITS'(1) << free_bit);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_vld  <= '0;
      base      <= '0;
      scan_ptr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) base <= cfg_base;
      if (cmd.wr_alloc || cmd.wr_free) word_vld[rd_word] <= 1'b1;
      if (cmd.scan_clr) begin
        scan_ptr <= '0;
      end else if (cmd.rd_scan) begin
        scan_ptr <= scan_ptr + 1'b1;
      end
      if (cmd.wr_alloc || cmd.wr_free || cmd.out_full || cmd.out_outside) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_alloc) begin
      out_addr   <= {alloc_pg, pba_pkg::PAGE_SHIFT'(0)};
      out_status <= pba_pkg::ST_OK;
    end else if (cmd.wr_free) begin
      out_addr   <= '0;
      out_status <= pba_pkg::ST_OK;
    end else if (cmd.out_full) begin
      out_addr   <= '0;
      out_status <= pba_pkg::ST_FULL;
    end else if (cmd.out_outside) begin
      out_addr   <= '0;
      out_status <= pba_pkg::ST_OUTSIDE;
    end
  end

endmodule

`default_nettype wire

/* hdl/pba_ctrl.sv */
// Controller of the page bitmap allocator: sequences the bitmap scan,
// the read-modify-write and the result hand-off. Depends on pba_pkg.
`default_nettype none

module pba_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              in_op,
  output logic                   in_ready,
  input  wire pba_pkg::dp_stat_t stat,
  output pba_pkg::dp_cmd_t       cmd
);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_ALLOC_RD  = 3'd1;
  localparam logic [2:0] S_ALLOC_CHK = 3'd2;
  localparam logic [2:0] S_ALLOC_WR  = 3'd3;
  localparam logic [2:0] S_FREE_RD   = 3'd4;
  localparam logic [2:0] S_FREE_WR   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = !rst && (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load     = 1'b1;
          cmd.scan_clr = 1'b1;
          state_next   = (in_op == pba_pkg::OP_FREE) ? S_FREE_RD : S_ALLOC_RD;
        end
      end
      S_ALLOC_RD: begin
        cmd.rd_scan = 1'b1;
        state_next  = S_ALLOC_CHK;
      end
      S_ALLOC_CHK: begin
        if (!stat.word_full) begin
          state_next = S_ALLOC_WR;
        end else if (!stat.last_word) begin
          cmd.rd_scan = 1'b1;
        end else if (stat.out_free) begin
          cmd.out_full = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_ALLOC_WR: begin
        if (stat.out_free) begin
          cmd.wr_alloc = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_FREE_RD: begin
        if (!stat.outside) begin
          cmd.rd_free = 1'b1;
          state_next  = S_FREE_WR;
        end else if (stat.out_free) begin
          cmd.out_outside = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_FREE_WR: begin
        if (stat.out_free) begin
          cmd.wr_free = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

/* dv/tb_page_bitmap_allocator.sv */
// Testbench for page_bitmap_allocator: directed and random allocate/free words with
// random stalls on both streams, checked against a bitmap tracker kept in the bench.
// Depends on pba_pkg and the page_bitmap_allocator RTL.
module tb_page_bitmap_allocator;

  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PLAN_TARGET = 1420;

  typedef enum logic [1:0] {STEP_REQ, STEP_CFG, STEP_SYNC} step_kind_t;

  typedef struct {
    step_kind_t  kind;
    logic        op;
    logic [31:0] addr;
    logic [19:0] base;
  } plan_step_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [1:0]  status;
  } page_reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [19:0] cfg_data = '0;

  plan_step_t  request_plan[$];
  page_reply_t due_replies[$];

  logic [pba_pkg::WORD_BITS-1:0] page_used [pba_pkg::MAP_WORDS];
  logic [19:0]                   heap_base;

  logic [19:0] gen_base;
  int used_lb;
  int n_plan;

  int n_pred;
  int n_checked = 0;
  int n_fail;
  int n_alloc, n_free, n_full, n_outside, n_cfg;
  int src_gap, src_calm;
  int snk_stall, snk_calm, snk_hold;
  bit hold_done;
  int idle_cycles = 0;

  page_bitmap_allocator i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic apply_page_request(input logic op, input logic [31:0] addr);
    page_reply_t rep;
    int w;
    int b;
    logic [31:0] pg;
    rep.addr = '0;
    rep.status = pba_pkg::ST_OK;
    if (op == pba_pkg::OP_ALLOC) begin
      w = 0;
      while (w < pba_pkg::MAP_WORDS && page_used[w] == '1) w++;
      if (w == pba_pkg::MAP_WORDS) begin
        rep.status = pba_pkg::ST_FULL;
      end else begin
        b = 0;
        while (b < pba_pkg::WORD_BITS - 1 && page_used[w][b]) b++;
        page_used[w][b] = 1'b1;
        pg = 32'(heap_base) + 32'(w * pba_pkg::WORD_BITS + b);
        rep.addr = pg << pba_pkg::PAGE_SHIFT;
      end
    end else begin
      pg = (addr - {heap_base, 12'h000}) >> pba_pkg::PAGE_SHIFT;
      if (pg >= pba_pkg::MAP_PAGES) begin
        rep.status = pba_pkg::ST_OUTSIDE;
      end else begin
        page_used[pg / pba_pkg::WORD_BITS][pg % pba_pkg::WORD_BITS] = 1'b0;
      end
    end
    due_replies.push_back(rep);
  endtask

  task automatic push_req(input logic op, input logic [31:0] addr);
    plan_step_t s;
    s.kind = STEP_REQ;
    s.op = op;
    s.addr = addr;
    s.base = '0;
    request_plan.push_back(s);
    n_plan++;
    if (op == pba_pkg::OP_ALLOC) begin
      if (used_lb < pba_pkg::MAP_PAGES) used_lb++;
    end else if (used_lb > 0) begin
      used_lb--;
    end
  endtask

  task automatic push_free(input int idx, input logic [11:0] low);
    push_req(pba_pkg::OP_FREE,
             ((32'(gen_base) + 32'(idx)) << pba_pkg::PAGE_SHIFT) | 32'(low));
  endtask

  task automatic push_step(input step_kind_t kind, input logic [19:0] base);
    plan_step_t s;
    s.kind = kind;
    s.op = pba_pkg::OP_ALLOC;
    s.addr = '0;
    s.base = base;
    request_plan.push_back(s);
    if (kind == STEP_CFG) gen_base = base;
  endtask

  task automatic random_mix(input int count, input int alloc_pct, input int free_pct);
    int r;
    int span;
    logic [11:0] low;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      low = $urandom_range(0, 1) ? 12'h000 : 12'($urandom_range(0, 4095));
      span = (used_lb > 0) ? used_lb : 1;
      if (r < alloc_pct) begin
        push_req(pba_pkg::OP_ALLOC, $urandom());
      end else if (r < alloc_pct + free_pct) begin
        if ($urandom_range(0, 4) == 0) push_free($urandom_range(0, pba_pkg::MAP_PAGES - 1), low);
        else push_free($urandom_range(0, span - 1), low);
      end else begin
        case ($urandom_range(0, 2))
          0: push_req(pba_pkg::OP_FREE, $urandom());
          1: push_free(pba_pkg::MAP_PAGES + $urandom_range(0, 63), low);
          default: push_free(-1 - int'($urandom_range(0, 63)), low);
        endcase
      end
      if ($urandom_range(0, 199) == 0) push_step(STEP_SYNC, '0);
    end
  endtask

  // driver: request words and register writes, in plan order
  always @(posedge clk) begin
    plan_step_t nxt;
    logic s_done;
    logic c_done;
    logic v_n;
    logic cv_n;
    int ahead;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      s_done = s_axis_tvalid && s_axis_tready;
      c_done = cfg_valid && cfg_ready;
      v_n = s_axis_tvalid && !s_done;
      cv_n = cfg_valid && !c_done;
      if (s_done) begin
        apply_page_request(s_axis_tuser[0], s_axis_tdata);
        n_pred++;
        if (s_axis_tuser[0] == pba_pkg::OP_ALLOC) n_alloc++;
        else n_free++;
        if (src_calm > 0) begin
          src_calm--;
          src_gap = 0;
        end else begin
          src_gap = gap_len();
          if ($urandom_range(0, 49) == 0) src_calm = $urandom_range(20, 80);
        end
      end
      if (c_done) begin
        heap_base = cfg_data;
        n_cfg++;
      end
      ahead = n_pred - n_checked - int'(m_axis_tvalid && m_axis_tready);
      if (!v_n && !cv_n) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (request_plan.size() != 0) begin
          case (request_plan[0].kind)
            STEP_REQ: begin
              nxt = request_plan.pop_front();
              s_axis_tuser <= nxt.op;
              s_axis_tdata <= nxt.addr;
              v_n = 1'b1;
            end
            STEP_CFG: begin
              if (ahead == 0) begin
                nxt = request_plan.pop_front();
                cfg_data <= nxt.base;
                cv_n = 1'b1;
              end
            end
            default: begin
              if (ahead == 0) nxt = request_plan.pop_front();
            end
          endcase
        end
      end
      s_axis_tvalid <= v_n;
      cfg_valid <= cv_n;
    end
  end

  // monitor: check each result word against the oldest prediction
  always @(posedge clk) begin
    page_reply_t want;
    logic rdy;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_replies.size() == 0) begin
          $display("%0t: unexpected word: expected none, got result_addr %h status %0d",
                   $time, m_axis_tdata, m_axis_tuser);
          n_fail++;
        end else begin
          want = due_replies.pop_front();
          if (m_axis_tdata !== want.addr) begin
            $display("%0t: result_addr mismatch: expected %h, got %h",
                     $time, want.addr, m_axis_tdata);
            n_fail++;
          end
          if (m_axis_tuser !== want.status) begin
            $display("%0t: status mismatch: expected %0d, got %0d",
                     $time, want.status, m_axis_tuser);
            n_fail++;
          end
          if (want.status == pba_pkg::ST_FULL) n_full++;
          if (want.status == pba_pkg::ST_OUTSIDE) n_outside++;
        end
        n_checked <= n_checked + 1;
      end
      if (!hold_done && n_checked >= 300) begin
        hold_done = 1'b1;
        snk_hold = 300;
      end
      if (snk_hold > 0) begin
        snk_hold--;
        rdy = 1'b0;
      end else if (snk_stall > 0) begin
        snk_stall--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
        if (snk_calm > 0) begin
          snk_calm--;
        end else if ($urandom_range(0, 2) == 0) begin
          snk_stall = gap_len();
          if ($urandom_range(0, 49) == 0) snk_calm = $urandom_range(30, 100);
        end
      end
      m_axis_tready <= rdy;
    end
  end

  // watchdog: stop when no word moves on any channel for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, idle_cycles);
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    for (int w = 0; w < pba_pkg::MAP_WORDS; w++) page_used[w] = '0;
    heap_base = '0;
    gen_base = '0;

    // directed: reuse of freed pages, unaligned and repeated frees, heap edges
    push_step(STEP_CFG, 20'h00400);
    push_req(pba_pkg::OP_ALLOC, 32'h0000_0000);
    push_req(pba_pkg::OP_ALLOC, 32'hFFFF_FFFF);
    push_req(pba_pkg::OP_ALLOC, $urandom());
    push_free(1, 12'h000);
    push_free(1, 12'h000);
    push_req(pba_pkg::OP_ALLOC, $urandom());
    push_free(2, 12'hFFF);
    push_req(pba_pkg::OP_ALLOC, $urandom());
    push_free(-1, 12'h000);
    push_free(pba_pkg::MAP_PAGES, 12'h000);
    push_free(pba_pkg::MAP_PAGES - 1, 12'hFFF);
    push_req(pba_pkg::OP_FREE, 32'h0000_0000);
    push_req(pba_pkg::OP_FREE, 32'hFFFF_FFFF);
    push_step(STEP_SYNC, '0);
    // top base: allocated addresses wrap past the top of the address space
    push_step(STEP_CFG, 20'hFFFFF);
    push_req(pba_pkg::OP_ALLOC, $urandom());
    push_req(pba_pkg::OP_ALLOC, $urandom());
    push_req(pba_pkg::OP_FREE, 32'hFFFF_F000);
    push_free(4, 12'h000);
    push_req(pba_pkg::OP_ALLOC, $urandom());

    push_step(STEP_CFG, 20'($urandom_range(1, 20'hFFFFE)));
    random_mix(120, 70, 22);
    // fill the heap, then keep hitting it while full
    push_step(STEP_CFG, 20'hFFFFF);
    while (used_lb < pba_pkg::MAP_PAGES) random_mix(1, 96, 2);
    random_mix(40, 80, 15);
    push_step(STEP_CFG, 20'h00000);
    random_mix(150, 35, 55);
    push_step(STEP_CFG, 20'($urandom()));
    random_mix((PLAN_TARGET - n_plan > 80) ? PLAN_TARGET - n_plan : 80, 55, 35);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (request_plan.size() != 0 || s_axis_tvalid || cfg_valid || n_pred != n_checked)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (due_replies.size() != 0) begin
      $display("%0t: %0d predicted words never arrived", $time, due_replies.size());
      n_fail++;
    end
    $display("Covered %0d requests (%0d allocates, %0d frees) over %0d heap base settings,",
             n_pred, n_alloc, n_free, n_cfg);
    $display("  with %0d heap-full and %0d outside-heap replies and one long output stall",
             n_full, n_outside);
    if (n_fail == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/pba_pkg.sv
hdl/pba_dp.sv
hdl/pba_ctrl.sv
hdl/page_bitmap_allocator.sv
dv/tb_page_bitmap_allocator.sv
